>>> design/hkua_pkg.sv
// Package for the HID keyboard usage to ASCII translator.
// Holds the usage ranges, character codes, lock state type and symbol tables.
// No dependencies.
package hkua_pkg;

    localparam int CfgIdxW = 1;

    // Register indexes of the configuration port.
    localparam logic [CfgIdxW-1:0] CFG_CAPS_LOCK = 1'b0;
    localparam logic [CfgIdxW-1:0] CFG_NUM_LOCK  = 1'b1;

    localparam logic [7:0] SHIFT_MASK     = 8'h22;

    localparam logic [7:0] KEY_LETTER_A   = 8'h04;
    localparam logic [7:0] KEY_LETTER_Z   = 8'h1d;
    localparam logic [7:0] KEY_DIGIT_1    = 8'h1e;
    localparam logic [7:0] KEY_DIGIT_0    = 8'h27;
    localparam logic [7:0] KEY_ENTER      = 8'h28;
    localparam logic [7:0] KEY_SPACE      = 8'h2c;
    localparam logic [7:0] KEY_SYM_FIRST  = 8'h2d;
    localparam logic [7:0] KEY_SYM_LAST   = 8'h38;
    localparam logic [7:0] KEY_PAD_OP_1ST = 8'h54;
    localparam logic [7:0] KEY_PAD_OP_END = 8'h58;
    localparam logic [7:0] KEY_PAD_1      = 8'h59;
    localparam logic [7:0] KEY_PAD_9      = 8'h61;
    localparam logic [7:0] KEY_PAD_ZERO   = 8'h62;
    localparam logic [7:0] KEY_PAD_PERIOD = 8'h63;

    localparam logic [7:0] CHAR_LOWER_A   = 8'h61;
    localparam logic [7:0] CHAR_UPPER_A   = 8'h41;
    localparam logic [7:0] CHAR_ONE       = 8'h31;
    localparam logic [7:0] CHAR_ZERO      = 8'h30;
    localparam logic [7:0] CHAR_PERIOD    = 8'h2e;
    localparam logic [7:0] CHAR_SPACE     = 8'h20;
    localparam logic [7:0] CODE_ENTER     = 8'h13;
    localparam logic [7:0] CHAR_NONE      = 8'h00;

    // Lock state held by the configuration registers.
    typedef struct packed {
        logic caps_lock;
        logic num_lock;
    } lock_state_t;

    // Shifted symbols of the digit row, from the 1 key to the 0 key.
    function automatic logic [7:0] digit_shifted(input logic [3:0] idx);
        logic [7:0] code;
        unique case (idx)
            4'd0:    code = 8'h21;
            4'd1:    code = 8'h40;
            4'd2:    code = 8'h23;
            4'd3:    code = 8'h24;
            4'd4:    code = 8'h25;
            4'd5:    code = 8'h5e;
            4'd6:    code = 8'h26;
            4'd7:    code = 8'h2a;
            4'd8:    code = 8'h28;
            4'd9:    code = 8'h29;
            default: code = CHAR_NONE;
        endcase
        return code;
    endfunction

    // Symbol keys from minus to slash, unshifted.
    function automatic logic [7:0] sym_lower(input logic [3:0] idx);
        logic [7:0] code;
        unique case (idx)
            4'd0:    code = 8'h2d;
            4'd1:    code = 8'h3d;
            4'd2:    code = 8'h5b;
            4'd3:    code = 8'h5d;
            4'd4:    code = 8'h5c;
            4'd5:    code = 8'h20;
            4'd6:    code = 8'h3b;
            4'd7:    code = 8'h27;
            4'd8:    code = 8'h60;
            4'd9:    code = 8'h2c;
            4'd10:   code = 8'h2e;
            4'd11:   code = 8'h2f;
            default: code = CHAR_NONE;
        endcase
        return code;
    endfunction

    // Symbol keys from minus to slash, shifted.
    function automatic logic [7:0] sym_upper(input logic [3:0] idx);
        logic [7:0] code;
        unique case (idx)
            4'd0:    code = 8'h5f;
            4'd1:    code = 8'h2b;
            4'd2:    code = 8'h7b;
            4'd3:    code = 8'h7d;
            4'd4:    code = 8'h7c;
            4'd5:    code = 8'h7e;
            4'd6:    code = 8'h3a;
            4'd7:    code = 8'h22;
            4'd8:    code = 8'h7e;
            4'd9:    code = 8'h3c;
            4'd10:   code = 8'h3e;
            4'd11:   code = 8'h3f;
            default: code = CHAR_NONE;
        endcase
        return code;
    endfunction

    // Keypad operators from slash to keypad Enter.
    function automatic logic [7:0] pad_ops(input logic [2:0] idx);
        logic [7:0] code;
        unique case (idx)
            3'd0:    code = 8'h2f;
            3'd1:    code = 8'h2a;
            3'd2:    code = 8'h2d;
            3'd3:    code = 8'h2b;
            3'd4:    code = CODE_ENTER;
            default: code = CHAR_NONE;
        endcase
        return code;
    endfunction

endpackage

>>> design/hkua_cfg_regs.sv
// Configuration registers of the translator: caps lock and num lock.
// Depends on hkua_pkg.
module hkua_cfg_regs
    import hkua_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic               cfg_data,
    output lock_state_t        locks
);

    lock_state_t locks_reg;
    lock_state_t locks_next;

    always_comb
    begin
        locks_next = locks_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_CAPS_LOCK: locks_next.caps_lock = cfg_data;
                CFG_NUM_LOCK:  locks_next.num_lock  = cfg_data;
                default:       locks_next = locks_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            locks_reg <= '0;
        end
        else
        begin
            locks_reg <= locks_next;
        end
    end

    assign locks = locks_reg;

endmodule

>>> design/hkua_translate.sv
// Combinational translation of one modifier byte and usage code to ASCII.
// Depends on hkua_pkg for the usage ranges and the symbol tables.
module hkua_translate
    import hkua_pkg::*;
(
    input  lock_state_t locks,
    input  logic [7:0]  modifiers,
    input  logic [7:0]  key_usage,
    output logic [7:0]  ascii_code
);

    logic       shift;
    logic [7:0] letter_off;
    logic [7:0] digit_off;
    logic [7:0] pad_off;
    logic [7:0] sym_off;
    logic [7:0] op_off;

    assign shift      = (modifiers & SHIFT_MASK) != 8'h00;
    assign letter_off = key_usage - KEY_LETTER_A;
    assign digit_off  = key_usage - KEY_DIGIT_1;
    assign pad_off    = key_usage - KEY_PAD_1;
    assign sym_off    = key_usage - KEY_SYM_FIRST;
    assign op_off     = key_usage - KEY_PAD_OP_1ST;

    always_comb
    begin
        priority if (key_usage >= KEY_LETTER_A && key_usage <= KEY_LETTER_Z)
        begin
            // Caps lock flips the case that shift selects.
            ascii_code = ((shift ^ locks.caps_lock) ? CHAR_UPPER_A : CHAR_LOWER_A)
                         + letter_off;
        end
        else if (key_usage >= KEY_DIGIT_1 && key_usage <= KEY_DIGIT_0)
        begin
            if (shift)
                ascii_code = digit_shifted(digit_off[3:0]);
            else if (key_usage == KEY_DIGIT_0)
                ascii_code = CHAR_ZERO;
            else
                ascii_code = CHAR_ONE + digit_off;
        end
        else if (key_usage >= KEY_PAD_1 && key_usage <= KEY_PAD_9)
        begin
            ascii_code = locks.num_lock ? (CHAR_ONE + pad_off) : CHAR_NONE;
        end
        else if (key_usage >= KEY_SYM_FIRST && key_usage <= KEY_SYM_LAST)
        begin
            ascii_code = shift ? sym_upper(sym_off[3:0]) : sym_lower(sym_off[3:0]);
        end
        else if (key_usage >= KEY_PAD_OP_1ST && key_usage <= KEY_PAD_OP_END)
        begin
            ascii_code = pad_ops(op_off[2:0]);
        end
        else if (key_usage == KEY_SPACE)
        begin
            ascii_code = CHAR_SPACE;
        end
        else if (key_usage == KEY_ENTER)
        begin
            ascii_code = CODE_ENTER;
        end
        else if (key_usage == KEY_PAD_ZERO)
        begin
            ascii_code = locks.num_lock ? CHAR_ZERO : CHAR_NONE;
        end
        else if (key_usage == KEY_PAD_PERIOD)
        begin
            ascii_code = locks.num_lock ? CHAR_PERIOD : CHAR_NONE;
        end
        else
        begin
            ascii_code = CHAR_NONE;
        end
    end

endmodule

>>> design/hid_keyboard_usage_to_ascii.sv
// Top level of the HID boot keyboard usage to ASCII translator.
// Depends on hkua_pkg, hkua_cfg_regs and hkua_translate.
//
// The block turns one keyboard report pair (modifier byte and key usage code)
// into one ASCII code, 0 when the key has no mapping. An item is taken at
// every rising edge where start is high; busy never rises, so a new item may
// be started in every cycle. The pair is captured in an input register, the
// translation runs through one short level of compares and small constant
// tables, and the code lands in a result register: each result appears on
// ascii_code with done high for exactly one cycle, in the order the items were
// taken. The receiver cannot hold results off, and none is needed since the
// block keeps no backlog. Caps lock and num lock are written through the
// cfg_write port (index 0 is caps lock, index 1 is num lock, bit 0 of cfg_data
// is the new value); the user must write them only while no item is in flight,
// and the block does not enforce it. They apply to items started after a write.
module hid_keyboard_usage_to_ascii
    import hkua_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [7:0]         modifiers,
    input  logic [7:0]         key_usage,
    output logic               done,
    output logic [7:0]         ascii_code,
    input  logic               cfg_write,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic               cfg_data
);

    lock_state_t locks;

    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] mods_reg;
    logic [7:0] key_reg;
    logic       done_reg;
    logic       done_next;
    logic [7:0] code_reg;
    logic [7:0] code_next;
    logic       accept;

    // Every cycle is free for a new item, so busy stays low.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    hkua_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .locks     (locks)
    );

    hkua_translate u_translate (
        .locks      (locks),
        .modifiers  (mods_reg),
        .key_usage  (key_reg),
        .ascii_code (code_next)
    );

    assign in_valid_next = accept;
    assign done_next     = in_valid_reg;

    // Control flags are reset; the payload registers are loaded on use.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mods_reg <= modifiers;
            key_reg  <= key_usage;
        end
        if (in_valid_reg)
        begin
            code_reg <= code_next;
        end
    end

    assign done       = done_reg;
    assign ascii_code = code_reg;

    // Every accepted item passes the input register and reaches the result register.
    a_start_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ##1 done)
        else $error("accepted item produced no result");

    // No result appears without an accepted item behind it.
    a_done_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 2))
        else $error("result strobe without an accepted item");

    // A held result with no new item behind it keeps its code.
    a_code_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |=> $stable(code_reg))
        else $error("result register changed without an item");

    // Keys that need num lock give zero while it is off.
    a_pad_needs_numlock: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !locks.num_lock && !cfg_write
         && key_reg >= KEY_PAD_1 && key_reg <= KEY_PAD_PERIOD)
        |=> (code_reg == CHAR_NONE))
        else $error("keypad key translated with num lock off");

endmodule
